>>> rtl/core/tsf_pkg.sv
// tsf_pkg: shared types, constants and codes for the transport stream
// packet aligner and pid filter. No dependencies; used by every rtl/core file.
package tsf_pkg;

    // stream geometry and sizing
    localparam int PACKET_LEN    = 188;
    localparam int FILTER_DEPTH  = 32;
    localparam int COUNT_WIDTH   = 32;
    localparam int FILL_W        = $clog2(PACKET_LEN + 1);
    localparam int POS_W         = $clog2(PACKET_LEN);
    localparam int ENTRY_INDEX_W = 5;
    localparam int PID_W         = 13;
    localparam int PID_COUNT_W   = 6;
    localparam int OUT_COUNT_W   = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 6;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [4:0] PID_HI_MASK = 5'h1f;

    // item command codes
    localparam logic CMD_STREAM = 1'b0;
    localparam logic CMD_TABLE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_ANY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PID_COUNT  = 2'd1;

    // input transaction payload
    typedef struct packed {
        logic                     cmd;
        logic [7:0]               data_byte;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [PID_W-1:0]         entry_pid;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   out_valid;
        logic                   packet_start;
        logic                   packet_last;
        logic                   sync_locked;
        logic [OUT_COUNT_W-1:0] total_count;
        logic [OUT_COUNT_W-1:0] matched_count;
        logic [OUT_COUNT_W-1:0] bad_sync_count;
    } out_item_t;

    // view of the look-ahead window
    typedef struct packed {
        logic             full;
        logic [7:0]       lead_byte;
        logic [PID_W-1:0] pid;
    } win_status_t;

endpackage

>>> rtl/core/tsf_window.sv
// tsf_window: 188-byte look-ahead shift line with fill tracking.
// Depends on tsf_pkg.
module tsf_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  logic [7:0]           new_byte,
    output tsf_pkg::win_status_t status
);

    logic [7:0]                 win_reg [tsf_pkg::PACKET_LEN];
    logic [tsf_pkg::FILL_W-1:0] fill_reg;
    logic [tsf_pkg::FILL_W-1:0] fill_next;
    logic                       full;

    assign full = (fill_reg == tsf_pkg::FILL_W'(tsf_pkg::PACKET_LEN));

    // fill level saturates once the window holds a whole packet
    always_comb
    begin
        fill_next = fill_reg;
        if (shift_en && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // oldest byte at index 0, arriving byte enters at the top
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < tsf_pkg::PACKET_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[tsf_pkg::PACKET_LEN - 1] <= new_byte;
        end
    end

    // pid sits in the low 5 bits of byte 1 and all of byte 2
    assign status.full      = full;
    assign status.lead_byte = win_reg[0];
    assign status.pid       = {win_reg[1][4:0] & tsf_pkg::PID_HI_MASK, win_reg[2]};

endmodule

>>> rtl/core/tsf_pid_match.sv
// tsf_pid_match: pid table storage and parallel match against a lookup pid.
// Depends on tsf_pkg.
module tsf_pid_match (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tsf_pkg::ENTRY_INDEX_W-1:0] wr_index,
    input  logic [tsf_pkg::PID_W-1:0]         wr_pid,
    input  logic                              accept_any,
    input  logic [tsf_pkg::PID_COUNT_W-1:0]   pid_count,
    input  logic [tsf_pkg::PID_W-1:0]         lookup_pid,
    output logic                              hit
);

    logic [tsf_pkg::PID_W-1:0]        table_reg [tsf_pkg::FILTER_DEPTH];
    logic [tsf_pkg::FILTER_DEPTH-1:0] lane_hit;

    // table write, slots beyond the depth are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsf_pkg::FILTER_DEPTH; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < tsf_pkg::FILTER_DEPTH; i++)
            begin
                if (32'(wr_index) == 32'(i))
                begin
                    table_reg[i] <= wr_pid;
                end
            end
        end
    end

    // one comparator per slot; a count above the depth covers every slot
    always_comb
    begin
        for (int i = 0; i < tsf_pkg::FILTER_DEPTH; i++)
        begin
            lane_hit[i] = (32'(i) < 32'(pid_count)) && (table_reg[i] == lookup_pid);
        end
    end

    assign hit = accept_any || (|lane_hit);

endmodule

>>> rtl/core/ts_sync_pid_filter.sv
// ts_sync_pid_filter: top level, input register, sync tracking, counters
// and result register. Depends on tsf_pkg, tsf_window and tsf_pid_match.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one transport stream
//   byte (cmd stream) or one pid table write (cmd table) per transaction.
//   result channel (result_valid/result_ready/result) returns exactly one
//   result per item: the byte leaving the 188-byte window when it belongs
//   to a passed packet, start/last marks, lock state and the three
//   saturating counters.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes accept_any
//   (index 0) and pid_count (index 1); cfg_ready is always high. Write it
//   only while no item is in flight.
//   An accepted item moves from the input register to the result register;
//   one item is accepted every cycle while the result side is not stalled,
//   set by the single window/match/counter stage between the two registers.
//   A stalled result holds in the result register while one more item
//   waits in the input register; item_ready drops only when both are full.
//   Reset clears lock, position, fill level, counters, the pid table and
//   the registers (accept_any 0, pid_count 1); the first 188 bytes only
//   fill the window and produce results without a byte.
module ts_sync_pid_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  tsf_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tsf_pkg::out_item_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic ST_HUNT   = 1'b0;
    localparam logic ST_LOCKED = 1'b1;

    logic                            in_vld_reg;
    tsf_pkg::in_item_t               in_reg;
    logic                            res_vld_reg;
    tsf_pkg::out_item_t              res_reg;
    tsf_pkg::out_item_t              res_next;

    logic                            state_reg, state_next;
    logic [tsf_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                            pass_reg, pass_next;
    logic [tsf_pkg::COUNT_WIDTH-1:0] total_reg, total_next;
    logic [tsf_pkg::COUNT_WIDTH-1:0] matched_reg, matched_next;
    logic [tsf_pkg::COUNT_WIDTH-1:0] bad_reg, bad_next;
    logic                            accept_any_reg;
    logic [tsf_pkg::PID_COUNT_W-1:0] pid_count_reg;

    logic                            advance;
    logic                            process;
    logic                            shift_en;
    logic                            tbl_wr;
    logic                            hit;
    logic                            start;
    logic                            emit;
    tsf_pkg::win_status_t            win;

    localparam logic [tsf_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // handshake: result register frees the stage, input register feeds it
    assign advance      = !res_vld_reg || result_ready;
    assign process      = in_vld_reg && advance;
    assign item_ready   = !in_vld_reg || advance;
    assign result_valid = res_vld_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_any_reg <= 1'b0;
            pid_count_reg  <= tsf_pkg::PID_COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsf_pkg::REG_ACCEPT_ANY: accept_any_reg <= cfg_data[0];
                tsf_pkg::REG_PID_COUNT:  pid_count_reg  <= cfg_data[tsf_pkg::PID_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign shift_en = process && (in_reg.cmd == tsf_pkg::CMD_STREAM);
    assign tbl_wr   = process && (in_reg.cmd == tsf_pkg::CMD_TABLE);

    tsf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .new_byte (in_reg.data_byte),
        .status   (win)
    );

    tsf_pid_match u_pid_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (tbl_wr),
        .wr_index   (in_reg.entry_index),
        .wr_pid     (in_reg.entry_pid),
        .accept_any (accept_any_reg),
        .pid_count  (pid_count_reg),
        .lookup_pid (win.pid),
        .hit        (hit)
    );

    // sync tracking, packet decision and counters
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        pass_next    = pass_reg;
        total_next   = total_reg;
        matched_next = matched_reg;
        bad_next     = bad_reg;
        start        = 1'b0;
        emit         = 1'b0;
        res_next     = '0;

        if (shift_en && win.full)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (win.lead_byte == tsf_pkg::SYNC_BYTE &&
                        in_reg.data_byte == tsf_pkg::SYNC_BYTE)
                    begin
                        state_next = ST_LOCKED;
                        start      = 1'b1;
                    end
                end
                ST_LOCKED:
                begin
                    if (pos_reg == '0)
                    begin
                        if (win.lead_byte != tsf_pkg::SYNC_BYTE)
                        begin
                            if (bad_reg != COUNT_MAX)
                            begin
                                bad_next = bad_reg + 1'b1;
                            end
                            state_next = ST_HUNT;
                            pass_next  = 1'b0;
                        end
                        else
                        begin
                            start = 1'b1;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default: ;
            endcase

            // packet start: count it and decide whether it passes
            if (start)
            begin
                emit      = 1'b1;
                pass_next = hit;
                if (total_reg != COUNT_MAX)
                begin
                    total_next = total_reg + 1'b1;
                end
                if (hit && matched_reg != COUNT_MAX)
                begin
                    matched_next = matched_reg + 1'b1;
                end
            end

            if (emit && pass_next)
            begin
                res_next.out_byte     = win.lead_byte;
                res_next.out_valid    = 1'b1;
                res_next.packet_start = (pos_reg == '0);
                res_next.packet_last  = (pos_reg == tsf_pkg::POS_W'(tsf_pkg::PACKET_LEN - 1));
            end

            // byte position within the packet
            if (state_next == ST_LOCKED)
            begin
                if (pos_reg == tsf_pkg::POS_W'(tsf_pkg::PACKET_LEN - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = '0;
            end
        end

        res_next.sync_locked    = (state_next == ST_LOCKED);
        res_next.total_count    = tsf_pkg::OUT_COUNT_W'(total_next);
        res_next.matched_count  = tsf_pkg::OUT_COUNT_W'(matched_next);
        res_next.bad_sync_count = tsf_pkg::OUT_COUNT_W'(bad_next);
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            pos_reg     <= '0;
            pass_reg    <= 1'b0;
            total_reg   <= '0;
            matched_reg <= '0;
            bad_reg     <= '0;
        end
        else if (process)
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            pass_reg    <= pass_next;
            total_reg   <= total_next;
            matched_reg <= matched_next;
            bad_reg     <= bad_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            res_reg <= res_next;
        end
    end

    // a passed packet always opens with the sync byte
    a_start_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.packet_start |-> res_reg.out_byte == tsf_pkg::SYNC_BYTE)
        else $error("packet start without sync byte");

    // the last byte of a packet is only emitted while locked
    a_last_locked: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.packet_last |-> res_reg.sync_locked && res_reg.out_valid)
        else $error("packet last outside lock");

    // a waiting item stays put while the result side is stalled
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_reg))
        else $error("input register lost a stalled transaction");

    // bad-sync counter never goes backwards
    a_bad_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> bad_reg >= $past(bad_reg))
        else $error("bad sync counter decreased");

endmodule
